// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every enabled clock edge.
`define ASSERT_AT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The expression must never be true at an enabled clock edge.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ----- rtl/idisp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idisp_pkg
// Types, widths and constants of the displacement and phase-jump checker.
// ----------------------------------------------------------------------------
package idisp_pkg;

    localparam int TILE_WIDTH_DEF = 256;

    localparam int PHASE_W    = 32;
    localparam int SCALE_W    = 32;
    localparam int THRESH_W   = 17;
    localparam int CNT_W      = 32;
    localparam int DISP_W     = 41;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 2;

    // Pi at 2^-20 rad, floor of pi * 2^20.
    localparam logic signed [PHASE_W:0] PI_Q20     = 33'sd3294198;
    localparam logic signed [PHASE_W:0] NEG_PI_Q20 = -33'sd3294198;

    // Half an output step, in product units of 2^-52 m.
    localparam logic signed [64:0] ROUND_HALF = 65'sd134217728;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd1311;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE  = 1'b0,
        REG_THRESH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                      valid;
        logic signed [PHASE_W-1:0] phase;
    } pix_t;

    localparam int PIX_W = $bits(pix_t);

    // Saturating add of a small increment to a counter.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W - 1){1'b0}}, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ----- rtl/insar_displacement_itoh_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insar_displacement_itoh_check_unit
// Converts unwrapped phase pixels to line-of-sight displacement and counts
// valid pixels, neighbor pairs and phase jumps larger than pi per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid / s_tready  one phase pixel
//  m_        out        m_tvalid / m_tready  displacement, counts, warning
//  cfg_      in         cfg_valid/cfg_ready  register index and data
//
//  One pixel per clock unless the output stalls; a result moves through
//  the stage registers to the output register. The upper neighbor comes
//  from a line RAM of TILE_WIDTH entries with a registered read, written
//  in the same cycle as it is read. A stalled output holds only as many
//  stages as are full; empty stages further up keep taking pixels. Reset
//  needs no clearing pass, and the configuration port is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module insar_displacement_itoh_check_unit #(
    parameter int TILE_WIDTH = idisp_pkg::TILE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] phase
    input  logic [idisp_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] phase_valid, [1] row_start, [2] first_row, [3] frame_start
    input  logic [idisp_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [40:0] displacement, [72:41] valid_pixel_count, [104:73] pair_count,
    // [136:105] jump_count, [143:137] zero
    output logic [idisp_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] displacement_valid, [1] wrap_warning
    output logic [idisp_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [idisp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [idisp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import idisp_pkg::*;

    localparam int COL_W = $clog2(TILE_WIDTH);

    // Configuration registers.
    logic signed [SCALE_W-1:0] scale_reg;
    logic [THRESH_W-1:0]       thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= '0;
            thresh_reg <= THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SCALE:  scale_reg  <= signed'(cfg_data[SCALE_W-1:0]);
                REG_THRESH: thresh_reg <= cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage valids and enables. A stage loads when it is empty or its
    // contents move on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic accept;

    assign en5    = !v5_reg || m_tready;
    assign en4    = !v4_reg || en5;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign s_tready = en1;
    assign accept = s_tvalid && en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Input fields.
    logic signed [PHASE_W-1:0] in_phase;
    logic in_pv, in_row_start, in_first_row, in_frame_start;

    assign in_phase       = signed'(s_tdata[PHASE_W-1:0]);
    assign in_pv          = s_tuser[0];
    assign in_row_start   = s_tuser[1];
    assign in_first_row   = s_tuser[2];
    assign in_frame_start = s_tuser[3];

    // Column tracking and left neighbor, updated on every input transfer.
    logic [COL_W-1:0] column_reg, column_next;
    pix_t             left_reg, in_pix;

    assign in_pix.valid = in_pv;
    assign in_pix.phase = in_phase;

    always_comb begin
        if (in_row_start || column_reg == COL_W'(TILE_WIDTH - 1)) begin
            column_next = '0;
        end else begin
            column_next = column_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            left_reg   <= '0;
        end else if (accept) begin
            column_reg <= column_next;
            left_reg   <= in_pix;
        end
    end

    // Line store: the old entry is read while the new pixel replaces it.
    // The read data is held by the RAM until the next transfer.
    logic [PIX_W-1:0] upper_data;
    pix_t             upper_pix;

    idisp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TILE_WIDTH)
    ) u_line_ram (
        .clk   (aclk),
        .we    (accept),
        .waddr (column_next),
        .wdata (in_pix),
        .re    (accept),
        .raddr (column_next),
        .rdata (upper_data)
    );

    assign upper_pix = pix_t'(upper_data);

    // Stage 1: pixel and its left neighbor.
    logic signed [PHASE_W-1:0] s1_phase_reg;
    logic s1_pv_reg, s1_row_start_reg, s1_first_row_reg, s1_frame_start_reg;
    pix_t s1_left_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_phase_reg       <= in_phase;
            s1_pv_reg          <= in_pv;
            s1_row_start_reg   <= in_row_start;
            s1_first_row_reg   <= in_first_row;
            s1_frame_start_reg <= in_frame_start;
            s1_left_reg        <= left_reg;
        end
    end

    // Pair and jump detection against both neighbors.
    logic                    left_ok, up_ok, left_jump, up_jump;
    logic signed [PHASE_W:0] diff_left, diff_up;
    logic [1:0]              pair_inc, jump_inc;

    assign left_ok = s1_pv_reg && !s1_row_start_reg && s1_left_reg.valid;
    assign up_ok   = s1_pv_reg && !s1_first_row_reg && upper_pix.valid;

    assign diff_left = {s1_phase_reg[PHASE_W-1], s1_phase_reg}
                     - {s1_left_reg.phase[PHASE_W-1], s1_left_reg.phase};
    assign diff_up   = {s1_phase_reg[PHASE_W-1], s1_phase_reg}
                     - {upper_pix.phase[PHASE_W-1], upper_pix.phase};

    assign left_jump = left_ok && (diff_left > PI_Q20 || diff_left < NEG_PI_Q20);
    assign up_jump   = up_ok && (diff_up > PI_Q20 || diff_up < NEG_PI_Q20);

    assign pair_inc = {1'b0, left_ok} + {1'b0, up_ok};
    assign jump_inc = {1'b0, left_jump} + {1'b0, up_jump};

    // Stage 2: product and counter increments.
    logic signed [63:0] s2_prod_reg;
    logic               s2_pv_reg, s2_frame_start_reg;
    logic [1:0]         s2_pair_inc_reg, s2_jump_inc_reg;

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            s2_prod_reg        <= s1_phase_reg * scale_reg;
            s2_pv_reg          <= s1_pv_reg;
            s2_frame_start_reg <= s1_frame_start_reg;
            s2_pair_inc_reg    <= pair_inc;
            s2_jump_inc_reg    <= jump_inc;
        end
    end

    // Round to nearest, ties up. The product never exceeds 2^62 in
    // magnitude, so the 2^-24 m result always fits the output width.
    logic signed [64:0]       rnd_sum;
    logic signed [DISP_W-1:0] disp_rnd;

    assign rnd_sum  = {s2_prod_reg[63], s2_prod_reg} + ROUND_HALF;
    assign disp_rnd = {{(DISP_W - 37){rnd_sum[64]}}, rnd_sum[64:28]};

    // Running counters; they always hold the totals of the pixel in stage 3.
    logic [CNT_W-1:0] valid_total_reg, valid_total_next;
    logic [CNT_W-1:0] pair_total_reg, pair_total_next;
    logic [CNT_W-1:0] jump_total_reg, jump_total_next;

    always_comb begin
        if (s2_frame_start_reg) begin
            valid_total_next = sat_add('0, {1'b0, s2_pv_reg});
            pair_total_next  = sat_add('0, s2_pair_inc_reg);
            jump_total_next  = sat_add('0, s2_jump_inc_reg);
        end else begin
            valid_total_next = sat_add(valid_total_reg, {1'b0, s2_pv_reg});
            pair_total_next  = sat_add(pair_total_reg, s2_pair_inc_reg);
            jump_total_next  = sat_add(jump_total_reg, s2_jump_inc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_total_reg <= '0;
            pair_total_reg  <= '0;
            jump_total_reg  <= '0;
        end else if (en3 && v2_reg) begin
            valid_total_reg <= valid_total_next;
            pair_total_reg  <= pair_total_next;
            jump_total_reg  <= jump_total_next;
        end
    end

    // Stage 3: displacement.
    logic signed [DISP_W-1:0] s3_disp_reg;
    logic                     s3_pv_reg;

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            s3_disp_reg <= s2_pv_reg ? disp_rnd : '0;
            s3_pv_reg   <= s2_pv_reg;
        end
    end

    // Stage 4: both sides of the warning compare.
    logic signed [DISP_W-1:0]   s4_disp_reg;
    logic                       s4_pv_reg;
    logic [CNT_W-1:0]           s4_valid_cnt_reg, s4_pair_cnt_reg, s4_jump_cnt_reg;
    logic [CNT_W+15:0]          s4_lhs_reg;
    logic [CNT_W+THRESH_W-1:0]  s4_rhs_reg;

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            s4_disp_reg      <= s3_disp_reg;
            s4_pv_reg        <= s3_pv_reg;
            s4_valid_cnt_reg <= valid_total_reg;
            s4_pair_cnt_reg  <= pair_total_reg;
            s4_jump_cnt_reg  <= jump_total_reg;
            s4_lhs_reg       <= {jump_total_reg, 16'b0};
            s4_rhs_reg       <= (CNT_W + THRESH_W)'(thresh_reg)
                              * (CNT_W + THRESH_W)'(pair_total_reg);
        end
    end

    // Stage 5: output register.
    logic signed [DISP_W-1:0] out_disp_reg;
    logic                     out_pv_reg, out_warn_reg;
    logic [CNT_W-1:0]         out_valid_cnt_reg, out_pair_cnt_reg, out_jump_cnt_reg;

    always_ff @(posedge aclk) begin
        if (en5 && v4_reg) begin
            out_disp_reg      <= s4_disp_reg;
            out_pv_reg        <= s4_pv_reg;
            out_valid_cnt_reg <= s4_valid_cnt_reg;
            out_pair_cnt_reg  <= s4_pair_cnt_reg;
            out_jump_cnt_reg  <= s4_jump_cnt_reg;
            out_warn_reg      <= {1'b0, s4_lhs_reg} > s4_rhs_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {{(M_TDATA_W - DISP_W - 3 * CNT_W){1'b0}},
                       out_jump_cnt_reg, out_pair_cnt_reg, out_valid_cnt_reg,
                       out_disp_reg};
    assign m_tuser  = {out_warn_reg, out_pv_reg};

    // Every jump is also a pair, and both clear together.
    `ASSERT_AT(a_jump_le_pair, aclk, aresetn, jump_total_reg <= pair_total_reg,
               "jump total exceeds pair total")
    `ASSERT_AT(a_accept_fills_s1, aclk, aresetn, accept |=> v1_reg,
               "accepted pixel did not reach stage 1")
    `ASSERT_NEVER(a_warn_without_pairs, aclk, aresetn,
                  m_tvalid && m_tuser[1] && m_tdata[104:73] == '0,
                  "warning raised with no pairs")
    `ASSERT_NEVER(a_invalid_disp_zero, aclk, aresetn,
                  m_tvalid && !m_tuser[0] && m_tdata[40:0] != '0,
                  "no-data pixel carries a displacement")

endmodule

// ----- rtl/idisp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idisp_ram
// Simple dual-port RAM, one write and one registered read port. A read of
// the address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module idisp_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
